### rtl/fpp_pkg.sv
// shared constants, types and the crc16 byte step for the framed packet parser
// no dependencies
package fpp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_START_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION      = 2'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic             start;
        logic [7:0]       frame_type;
        logic [7:0]       frame_flags;
        logic [7:0]       frame_seq;
        logic [LEN_W-1:0] payload_len;
    } frame_done_t;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/fpp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module fpp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

endmodule

### rtl/fpp_parser.sv
// byte parser: start byte hunt, header capture, crc check, payload writes to the store
// depends on fpp_pkg
module fpp_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          in_accept,
    input  logic [7:0]                    rx_byte,
    output logic                          wr_en,
    output logic [fpp_pkg::ADDR_W-1:0]    wr_addr,
    output logic [7:0]                    wr_data,
    output fpp_pkg::frame_done_t          done
);
    import fpp_pkg::*;

    typedef enum logic [3:0] {
        PH_SOF0, PH_SOF1, PH_VER, PH_TYPE, PH_FLAGS, PH_SEQ,
        PH_LEN_L, PH_LEN_H, PH_PAYLOAD, PH_CRC_L, PH_CRC_H
    } phase_t;

    phase_t           phase_reg;
    logic [7:0]       start_first_reg;
    logic [7:0]       start_second_reg;
    logic [7:0]       version_reg;
    logic [7:0]       type_reg;
    logic [7:0]       flags_reg;
    logic [7:0]       seq_reg;
    logic [7:0]       len_lo_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] fill_reg;
    logic [15:0]      crc_reg;
    logic [7:0]       crc_lo_reg;

    logic [15:0]      crc_next;
    logic [15:0]      full_len;
    logic [LEN_W-1:0] fill_next;
    logic             crc_match;
    phase_t           resync_phase;

    assign crc_next     = crc16_step(crc_reg, rx_byte);
    assign full_len     = {rx_byte, len_lo_reg};
    assign fill_next    = fill_reg + LEN_W'(1);
    assign crc_match    = ({rx_byte, crc_lo_reg} == crc_reg);
    assign resync_phase = (rx_byte == start_first_reg) ? PH_SOF1 : PH_SOF0;

    assign wr_en   = in_accept && (phase_reg == PH_PAYLOAD);
    assign wr_addr = fill_reg[ADDR_W-1:0];
    assign wr_data = rx_byte;

    assign done.start        = in_accept && (phase_reg == PH_CRC_H) && crc_match;
    assign done.frame_type   = type_reg;
    assign done.frame_flags  = flags_reg;
    assign done.frame_seq    = seq_reg;
    assign done.payload_len  = len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_first_reg  <= 8'hAA;
            start_second_reg <= 8'h55;
            version_reg      <= 8'h01;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_FIRST:  start_first_reg  <= cfg_data;
                CFG_START_SECOND: start_second_reg <= cfg_data;
                CFG_VERSION:      version_reg      <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SOF0;
            type_reg   <= '0;
            flags_reg  <= '0;
            seq_reg    <= '0;
            len_lo_reg <= '0;
            len_reg    <= '0;
            fill_reg   <= '0;
            crc_reg    <= CRC_INIT;
            crc_lo_reg <= '0;
        end
        else if (in_accept)
        begin
            case (phase_reg)
                PH_SOF0:
                begin
                    if (rx_byte == start_first_reg)
                        phase_reg <= PH_SOF1;
                end
                PH_SOF1:
                begin
                    if (rx_byte == start_second_reg)
                    begin
                        phase_reg <= PH_VER;
                        crc_reg   <= CRC_INIT;
                    end
                    else if (rx_byte != start_first_reg)
                        phase_reg <= PH_SOF0;
                end
                PH_VER:
                begin
                    if (rx_byte != version_reg)
                        phase_reg <= resync_phase;
                    else
                    begin
                        crc_reg   <= crc_next;
                        phase_reg <= PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_reg  <= rx_byte;
                    crc_reg   <= crc_next;
                    phase_reg <= PH_FLAGS;
                end
                PH_FLAGS:
                begin
                    flags_reg <= rx_byte;
                    crc_reg   <= crc_next;
                    phase_reg <= PH_SEQ;
                end
                PH_SEQ:
                begin
                    seq_reg   <= rx_byte;
                    crc_reg   <= crc_next;
                    phase_reg <= PH_LEN_L;
                end
                PH_LEN_L:
                begin
                    len_lo_reg <= rx_byte;
                    crc_reg    <= crc_next;
                    phase_reg  <= PH_LEN_H;
                end
                PH_LEN_H:
                begin
                    if (full_len > 16'(MAX_PAYLOAD))
                    begin
                        // oversize length, drop the frame
                        phase_reg  <= resync_phase;
                        type_reg   <= '0;
                        flags_reg  <= '0;
                        seq_reg    <= '0;
                        len_lo_reg <= '0;
                        crc_reg    <= CRC_INIT;
                    end
                    else
                    begin
                        len_reg   <= full_len[LEN_W-1:0];
                        fill_reg  <= '0;
                        crc_reg   <= crc_next;
                        phase_reg <= (full_len == 16'd0) ? PH_CRC_L : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    fill_reg <= fill_next;
                    crc_reg  <= crc_next;
                    if (fill_next >= len_reg)
                        phase_reg <= PH_CRC_L;
                end
                PH_CRC_L:
                begin
                    crc_lo_reg <= rx_byte;
                    phase_reg  <= PH_CRC_H;
                end
                PH_CRC_H:
                begin
                    phase_reg  <= crc_match ? PH_SOF0 : resync_phase;
                    type_reg   <= '0;
                    flags_reg  <= '0;
                    seq_reg    <= '0;
                    len_lo_reg <= '0;
                    len_reg    <= '0;
                    fill_reg   <= '0;
                    crc_reg    <= CRC_INIT;
                    crc_lo_reg <= '0;
                end
                default:
                begin
                    phase_reg  <= PH_SOF0;
                    type_reg   <= '0;
                    flags_reg  <= '0;
                    seq_reg    <= '0;
                    len_lo_reg <= '0;
                    len_reg    <= '0;
                    fill_reg   <= '0;
                    crc_reg    <= CRC_INIT;
                    crc_lo_reg <= '0;
                end
            endcase
        end
    end

endmodule

### rtl/fpp_emitter.sv
// result sequencer: reads the payload store one entry at a time into the output register
// depends on fpp_pkg
module fpp_emitter (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fpp_pkg::frame_done_t       done,
    output logic                       busy,
    output logic                       rd_en,
    output logic [fpp_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]                 rd_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 frame_type,
    output logic [7:0]                 frame_flags,
    output logic [7:0]                 frame_seq,
    output logic [6:0]                 payload_len,
    output logic                       has_payload_byte,
    output logic [7:0]                 payload_byte,
    output logic [5:0]                 byte_index,
    output logic                       last_of_frame
);
    import fpp_pkg::*;

    typedef enum logic [1:0] {E_IDLE, E_READ, E_LOAD} emit_state_t;

    emit_state_t      state_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [7:0]       type_reg;
    logic [7:0]       flags_reg;
    logic [7:0]       seq_reg;
    logic [LEN_W-1:0] len_reg;
    logic             out_valid_reg;

    logic             out_free;
    logic             is_last;
    logic             load_out;

    assign out_free = !out_valid_reg || out_ready;
    assign is_last  = ({1'b0, idx_reg} + LEN_W'(1)) == len_reg;
    assign busy     = (state_reg != E_IDLE);
    assign rd_en    = (state_reg == E_READ) && out_free && (len_reg != '0);
    assign rd_addr  = idx_reg;
    assign out_valid = out_valid_reg;
    assign load_out = (state_reg == E_LOAD) ||
                      ((state_reg == E_READ) && out_free && (len_reg == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= E_IDLE;
            idx_reg          <= '0;
            type_reg         <= '0;
            flags_reg        <= '0;
            seq_reg          <= '0;
            len_reg          <= '0;
            out_valid_reg    <= 1'b0;
            frame_type       <= '0;
            frame_flags      <= '0;
            frame_seq        <= '0;
            payload_len      <= '0;
            has_payload_byte <= 1'b0;
            payload_byte     <= '0;
            byte_index       <= '0;
            last_of_frame    <= 1'b0;
        end
        else
        begin
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                E_IDLE:
                begin
                    if (done.start)
                    begin
                        type_reg  <= done.frame_type;
                        flags_reg <= done.frame_flags;
                        seq_reg   <= done.frame_seq;
                        len_reg   <= done.payload_len;
                        idx_reg   <= '0;
                        state_reg <= E_READ;
                    end
                end
                E_READ:
                begin
                    if (out_free)
                    begin
                        if (len_reg == '0)
                        begin
                            // empty frame, header only
                            frame_type       <= type_reg;
                            frame_flags      <= flags_reg;
                            frame_seq        <= seq_reg;
                            payload_len      <= 7'(len_reg);
                            has_payload_byte <= 1'b0;
                            payload_byte     <= '0;
                            byte_index       <= '0;
                            last_of_frame    <= 1'b1;
                            state_reg        <= E_IDLE;
                        end
                        else
                            state_reg <= E_LOAD;
                    end
                end
                E_LOAD:
                begin
                    frame_type       <= type_reg;
                    frame_flags      <= flags_reg;
                    frame_seq        <= seq_reg;
                    payload_len      <= 7'(len_reg);
                    has_payload_byte <= 1'b1;
                    payload_byte     <= rd_data;
                    byte_index       <= 6'(idx_reg);
                    last_of_frame    <= is_last;
                    if (is_last)
                        state_reg <= E_IDLE;
                    else
                    begin
                        idx_reg   <= idx_reg + ADDR_W'(1);
                        state_reg <= E_READ;
                    end
                end
                default:
                    state_reg <= E_IDLE;
            endcase
        end
    end

endmodule

### rtl/framed_packet_parser_crc16.sv
// top level of the start-of-frame packet parser with crc16 check
// depends on fpp_pkg, fpp_ram, fpp_parser, fpp_emitter
//
// usage:
// - input channel in_valid / in_ready carries one received byte (rx_byte) per transfer
// - output channel out_valid / out_ready carries one result per payload byte of a frame
//   whose crc16 (ccitt-false) matches, or a single header-only result for an empty frame
// - config port cfg_we / cfg_index / cfg_data writes start bytes and expected version,
//   taken in the cycle cfg_we is high; the user must write only while the block is idle, the block does not enforce it
// - each header or payload byte is taken on its transfer; in_ready stays high while parsing
// - after the crc high byte of a good frame, in_ready drops while the payload store is read
//   back, each entry through a read state and then a load state into the output register,
//   so input stays held off until the whole frame has been emitted
// - the first result is loaded through the read and load states, an empty frame's from the read state
// - once the last result sits in the output register, in_ready rises again
// - a stalled receiver holds the output register and with it the readback sequence
// - reset returns the parser to start byte hunt and loads default register values
//   (0xaa, 0x55, 0x01); the payload store needs no clearing
module framed_packet_parser_crc16 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [fpp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    frame_type,
    output logic [7:0]                    frame_flags,
    output logic [7:0]                    frame_seq,
    output logic [6:0]                    payload_len,
    output logic                          has_payload_byte,
    output logic [7:0]                    payload_byte,
    output logic [5:0]                    byte_index,
    output logic                          last_of_frame
);
    import fpp_pkg::*;

    frame_done_t       done;
    logic              busy;
    logic              in_accept;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    // input held off during store readback, so reads and writes never meet
    assign in_ready  = !busy;
    assign in_accept = in_valid && in_ready;

    fpp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .rx_byte   (rx_byte),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .done      (done)
    );

    fpp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fpp_emitter u_emitter (
        .clk              (clk),
        .rst_n            (rst_n),
        .done             (done),
        .busy             (busy),
        .rd_en            (rd_en),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .frame_type       (frame_type),
        .frame_flags      (frame_flags),
        .frame_seq        (frame_seq),
        .payload_len      (payload_len),
        .has_payload_byte (has_payload_byte),
        .payload_byte     (payload_byte),
        .byte_index       (byte_index),
        .last_of_frame    (last_of_frame)
    );

endmodule
